// ----- hdl/amc_pkg.sv -----
// ----------------------------------------------------------------------------
// amc_pkg: shared types and constants for the actuator motion controller
// Request, command, link and register codes, reset values and the
// transaction structs passed between the controller modules.
// ----------------------------------------------------------------------------
package amc_pkg;

	// request types
	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_LATCHED  = 3'd1;
	localparam logic [2:0] REQ_MOMENT   = 3'd2;
	localparam logic [2:0] REQ_STOP     = 3'd3;
	localparam logic [2:0] REQ_CUSTOM   = 3'd4;
	localparam logic [2:0] REQ_LINK     = 3'd5;
	localparam logic [2:0] REQ_KEY      = 3'd6;
	localparam logic [2:0] REQ_SPEED    = 3'd7;

	// command codes
	localparam logic [2:0] CMD_STOP     = 3'd0;
	localparam logic [2:0] CMD_CUSTOM   = 3'd7;

	// movement states
	localparam logic [2:0] MOVE_STOPPED = 3'd0;

	// actuators
	localparam logic [1:0] ACT_LEGS     = 2'd1;
	localparam logic [1:0] ACT_LUMBAR   = 2'd2;

	// link states
	localparam logic [1:0] LINK_UNKNOWN = 2'd0;
	localparam logic [1:0] LINK_ONLINE  = 2'd2;
	localparam logic [1:0] LINK_BAD     = 2'd3;

	// register map (word index)
	localparam logic [2:0] REG_TIMEOUT    = 3'd0;
	localparam logic [2:0] REG_PERIOD     = 3'd1;
	localparam logic [2:0] REG_GRACE      = 3'd2;
	localparam logic [2:0] REG_STATIONARY = 3'd3;
	localparam logic [2:0] REG_STILL_SPD  = 3'd4;
	localparam logic [2:0] REG_LUMBAR     = 3'd5;

	localparam int unsigned PADDR_W = 5;

	// register reset values
	localparam logic [15:0] DEF_TIMEOUT_MS    = 16'd500;
	localparam logic [15:0] DEF_PERIOD_MS     = 16'd100;
	localparam logic [15:0] DEF_GRACE_MS      = 16'd1000;
	localparam logic [15:0] DEF_STATIONARY_MS = 16'd1000;
	localparam logic [14:0] DEF_STILL_SPEED   = 15'd2;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [15:0] period_ms;
		logic [15:0] grace_ms;
		logic [15:0] stationary_ms;
		logic [14:0] still_speed;
		logic        lumbar;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [31:0]        now_ms;
		logic [1:0]         actuator;
		logic               raise;
		logic [1:0]         new_link;
		logic [31:0]        key_code;
		logic [31:0]        command_word;
		logic signed [15:0] speed;
		logic               speed_valid;
	} item_t;

	typedef struct packed {
		logic [2:0]  move_state;
		logic        cmd_valid;
		logic [2:0]  cmd_code;
		logic [31:0] cmd_word;
		logic        flush_queue;
		logic        stall_stop;
	} result_t;

	// deadline reached when the wrapped difference is non-negative
	function automatic logic time_reached(input logic [31:0] now, input logic [31:0] t);
		logic [31:0] diff;
		diff = now - t;
		return ~diff[31];
	endfunction

endpackage

// ----- hdl/amc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// amc_cfg_regs: configuration register bank
// APB-style write/read access to the six timing, limit and lumbar-enable registers.
// ----------------------------------------------------------------------------
module amc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [amc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output amc_pkg::cfg_t                cfg
);

	amc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[amc_pkg::PADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms    <= amc_pkg::DEF_TIMEOUT_MS;
			cfg_q.period_ms     <= amc_pkg::DEF_PERIOD_MS;
			cfg_q.grace_ms      <= amc_pkg::DEF_GRACE_MS;
			cfg_q.stationary_ms <= amc_pkg::DEF_STATIONARY_MS;
			cfg_q.still_speed   <= amc_pkg::DEF_STILL_SPEED;
			cfg_q.lumbar        <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				amc_pkg::REG_TIMEOUT:    cfg_q.timeout_ms    <= pwdata[15:0];
				amc_pkg::REG_PERIOD:     cfg_q.period_ms     <= pwdata[15:0];
				amc_pkg::REG_GRACE:      cfg_q.grace_ms      <= pwdata[15:0];
				amc_pkg::REG_STATIONARY: cfg_q.stationary_ms <= pwdata[15:0];
				amc_pkg::REG_STILL_SPD:  cfg_q.still_speed   <= pwdata[14:0];
				amc_pkg::REG_LUMBAR:     cfg_q.lumbar        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			amc_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg_q.timeout_ms};
			amc_pkg::REG_PERIOD:     prdata = {16'd0, cfg_q.period_ms};
			amc_pkg::REG_GRACE:      prdata = {16'd0, cfg_q.grace_ms};
			amc_pkg::REG_STATIONARY: prdata = {16'd0, cfg_q.stationary_ms};
			amc_pkg::REG_STILL_SPD:  prdata = {17'd0, cfg_q.still_speed};
			amc_pkg::REG_LUMBAR:     prdata = {31'd0, cfg_q.lumbar};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

// ----- hdl/amc_core.sv -----
// ----------------------------------------------------------------------------
// amc_core: motion state and event decision logic
// Holds movement, link and timer state; works out one result per transaction
// and commits the new state when the transaction advances.
// ----------------------------------------------------------------------------
module amc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  amc_pkg::item_t    item,
	input  amc_pkg::cfg_t     cfg,
	output amc_pkg::result_t  result
);

	logic [2:0]  motion_q,    motion_d;
	logic [1:0]  link_q,      link_d;
	logic        dl_set_q,    dl_set_d;
	logic [31:0] dl_time_q,   dl_time_d;
	logic [31:0] send_time_q, send_time_d;
	logic        start_set_q, start_set_d;
	logic [31:0] start_time_q, start_time_d;
	logic        still_set_q, still_set_d;
	logic [31:0] still_time_q, still_time_d;

	logic        online;
	logic        act_ok;
	logic [2:0]  req_state;
	logic [1:0]  nl;
	logic [16:0] mag;
	logic [31:0] start_ref;
	logic [31:0] run_ms;
	logic [31:0] still_ms;
	logic [1:0]  moving_act;
	logic [2:0]  motion_m1;

	assign online    = (link_q == amc_pkg::LINK_ONLINE);
	assign act_ok    = (item.actuator <= amc_pkg::ACT_LEGS) ||
	                   ((item.actuator == amc_pkg::ACT_LUMBAR) && cfg.lumbar);
	assign req_state = {item.actuator, 1'b0} + (item.raise ? 3'd1 : 3'd2);
	assign nl        = (item.new_link == amc_pkg::LINK_BAD) ? amc_pkg::LINK_UNKNOWN
	                                                        : item.new_link;
	assign mag       = item.speed[15] ? (17'h10000 - {1'b0, item.speed}) : {1'b0, item.speed};
	assign start_ref = start_set_q ? start_time_q : item.now_ms;
	assign run_ms    = item.now_ms - start_ref;
	assign still_ms  = item.now_ms - still_time_q;
	assign motion_m1 = motion_q - 3'd1;
	assign moving_act = motion_m1[2:1];

	always_comb begin
		motion_d     = motion_q;
		link_d       = link_q;
		dl_set_d     = dl_set_q;
		dl_time_d    = dl_time_q;
		send_time_d  = send_time_q;
		start_set_d  = start_set_q;
		start_time_d = start_time_q;
		still_set_d  = still_set_q;
		still_time_d = still_time_q;
		result       = '0;

		case (item.req_type)
			amc_pkg::REQ_TICK: begin
				if (dl_set_q && amc_pkg::time_reached(item.now_ms, dl_time_q)) begin
					result.flush_queue = 1'b1;
					motion_d    = amc_pkg::MOVE_STOPPED;
					dl_set_d    = 1'b0;
					start_set_d = 1'b0;
					still_set_d = 1'b0;
					if (online) begin
						result.cmd_valid = 1'b1;
						result.cmd_code  = amc_pkg::CMD_STOP;
					end
				end
				if (amc_pkg::time_reached(item.now_ms, send_time_q)) begin
					if (online && (motion_d != amc_pkg::MOVE_STOPPED)) begin
						result.cmd_valid = 1'b1;
						result.cmd_code  = motion_d;
					end
					send_time_d = item.now_ms + {16'd0, cfg.period_ms};
				end
			end
			amc_pkg::REQ_LATCHED, amc_pkg::REQ_MOMENT: begin
				if (act_ok) begin
					if (!online) begin
						motion_d    = amc_pkg::MOVE_STOPPED;
						dl_set_d    = 1'b0;
						start_set_d = 1'b0;
						still_set_d = 1'b0;
					end else begin
						if (item.req_type == amc_pkg::REQ_LATCHED) begin
							dl_set_d = 1'b0;
						end else begin
							dl_set_d  = 1'b1;
							dl_time_d = item.now_ms + {16'd0, cfg.timeout_ms};
						end
						if ((item.req_type == amc_pkg::REQ_LATCHED) ||
						    (motion_q != req_state)) begin
							result.flush_queue = 1'b1;
							motion_d     = req_state;
							send_time_d  = item.now_ms;
							start_set_d  = 1'b1;
							start_time_d = item.now_ms;
							still_set_d  = 1'b0;
						end
					end
				end
			end
			amc_pkg::REQ_STOP, amc_pkg::REQ_CUSTOM: begin
				result.flush_queue = 1'b1;
				motion_d    = amc_pkg::MOVE_STOPPED;
				dl_set_d    = 1'b0;
				start_set_d = 1'b0;
				still_set_d = 1'b0;
				if (online) begin
					result.cmd_valid = 1'b1;
					if (item.req_type == amc_pkg::REQ_CUSTOM) begin
						result.cmd_code = amc_pkg::CMD_CUSTOM;
						result.cmd_word = item.command_word;
					end else begin
						result.cmd_code = amc_pkg::CMD_STOP;
					end
				end
			end
			amc_pkg::REQ_LINK: begin
				if (nl != link_q) begin
					result.flush_queue = online || (nl == amc_pkg::LINK_ONLINE);
					link_d = nl;
					if (nl != amc_pkg::LINK_ONLINE) begin
						motion_d    = amc_pkg::MOVE_STOPPED;
						dl_set_d    = 1'b0;
						start_set_d = 1'b0;
						still_set_d = 1'b0;
					end
				end
			end
			amc_pkg::REQ_KEY: begin
				if (item.key_code != 32'd0) begin
					result.flush_queue = 1'b1;
					motion_d    = amc_pkg::MOVE_STOPPED;
					dl_set_d    = 1'b0;
					start_set_d = 1'b0;
					still_set_d = 1'b0;
				end
			end
			default: begin
				// speed sample: stall detection
				if (motion_q == amc_pkg::MOVE_STOPPED) begin
					dl_set_d    = 1'b0;
					start_set_d = 1'b0;
					still_set_d = 1'b0;
				end else begin
					if (!start_set_q) begin
						start_set_d  = 1'b1;
						start_time_d = item.now_ms;
					end
					if ((run_ms >= {16'd0, cfg.grace_ms}) &&
					    (moving_act == item.actuator) && item.speed_valid) begin
						if (mag > {2'd0, cfg.still_speed}) begin
							still_set_d = 1'b0;
						end else if (!still_set_q) begin
							still_set_d  = 1'b1;
							still_time_d = item.now_ms;
						end else if (still_ms >= {16'd0, cfg.stationary_ms}) begin
							result.flush_queue = 1'b1;
							result.stall_stop  = 1'b1;
							motion_d    = amc_pkg::MOVE_STOPPED;
							dl_set_d    = 1'b0;
							start_set_d = 1'b0;
							still_set_d = 1'b0;
						end
					end
				end
			end
		endcase

		result.move_state = motion_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q     <= amc_pkg::MOVE_STOPPED;
			link_q       <= amc_pkg::LINK_UNKNOWN;
			dl_set_q     <= 1'b0;
			dl_time_q    <= 32'd0;
			send_time_q  <= 32'd0;
			start_set_q  <= 1'b0;
			start_time_q <= 32'd0;
			still_set_q  <= 1'b0;
			still_time_q <= 32'd0;
		end else if (advance) begin
			motion_q     <= motion_d;
			link_q       <= link_d;
			dl_set_q     <= dl_set_d;
			dl_time_q    <= dl_time_d;
			send_time_q  <= send_time_d;
			start_set_q  <= start_set_d;
			start_time_q <= start_time_d;
			still_set_q  <= still_set_d;
			still_time_q <= still_time_d;
		end
	end

endmodule

// ----- hdl/actuator_motion_controller_top.sv -----
// ----------------------------------------------------------------------------
// actuator_motion_controller_top: motion controller for three actuators
// Input register, decision logic and result register, plus the APB register
// bank for timing and stall-limit settings.
// ----------------------------------------------------------------------------
// A transaction taken into the input register moves on into the result
// register, and onto the result ports, when that register is free or being read.
// Throughput: one transaction per cycle while out_stall is low, set by the
// single input register and single result register around the decision logic.
// Reset: arst_n clears both pipeline valids, the motion/link/timer state and
// restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module actuator_motion_controller_top (
	input  logic                         clk,
	input  logic                         arst_n,

	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [amc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,

	// event channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   req_type,
	input  logic [31:0]                  now_ms,
	input  logic [1:0]                   actuator,
	input  logic                         raise,
	input  logic [1:0]                   new_link,
	input  logic [31:0]                  key_code,
	input  logic [31:0]                  command_word,
	input  logic signed [15:0]           speed,
	input  logic                         speed_valid,

	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   move_state,
	output logic                         cmd_valid,
	output logic [2:0]                   cmd_code,
	output logic [31:0]                  cmd_word,
	output logic                         flush_queue,
	output logic                         stall_stop
);

	amc_pkg::cfg_t    cfg;
	amc_pkg::item_t   item_s1;
	amc_pkg::result_t result;
	amc_pkg::result_t result_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             in_take;
	logic             advance;

	// Stage 1 moves into the result register whenever that register is empty
	// or its transaction is being taken this cycle, so the input register can
	// still take one transaction while a finished result waits.
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	amc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.req_type     <= req_type;
			item_s1.now_ms       <= now_ms;
			item_s1.actuator     <= actuator;
			item_s1.raise        <= raise;
			item_s1.new_link     <= new_link;
			item_s1.key_code     <= key_code;
			item_s1.command_word <= command_word;
			item_s1.speed        <= speed;
			item_s1.speed_valid  <= speed_valid;
		end
	end

	// state is committed only when the transaction moves to the result register
	amc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (~out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign move_state  = result_s2.move_state;
	assign cmd_valid   = result_s2.cmd_valid;
	assign cmd_code    = result_s2.cmd_code;
	assign cmd_word    = result_s2.cmd_word;
	assign flush_queue = result_s2.flush_queue;
	assign stall_stop  = result_s2.stall_stop;

endmodule

// ----- hdl/amc_checker.sv -----
// ----------------------------------------------------------------------------
// amc_checker: port-level checks for the actuator motion controller
// Watches the result channel and the register port; bound to the top level.
// ----------------------------------------------------------------------------
module amc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pready,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  move_state,
	input  logic        cmd_valid,
	input  logic [2:0]  cmd_code,
	input  logic [31:0] cmd_word,
	input  logic        flush_queue,
	input  logic        stall_stop
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(move_state) && $stable(cmd_valid)
			&& $stable(cmd_code) && $stable(cmd_word))
		else $error("result changed while stalled");

	// no command means a zero code and word; only custom carries a word
	a_cmd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!cmd_valid || cmd_code != amc_pkg::CMD_CUSTOM) |-> cmd_word == 32'd0
			&& (cmd_valid || cmd_code == amc_pkg::CMD_STOP))
		else $error("stray command payload");

	// a stall always flushes and leaves motion stopped without a command
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stall_stop |-> flush_queue && !cmd_valid
			&& move_state == amc_pkg::MOVE_STOPPED)
		else $error("stall result inconsistent");

	// a move command always repeats the movement state it reports
	a_move_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_valid && cmd_code != amc_pkg::CMD_STOP
			&& cmd_code != amc_pkg::CMD_CUSTOM |-> cmd_code == move_state)
		else $error("move command differs from state");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("register port not ready");

endmodule

bind actuator_motion_controller_top amc_checker u_amc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pready      (pready),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.move_state  (move_state),
	.cmd_valid   (cmd_valid),
	.cmd_code    (cmd_code),
	.cmd_word    (cmd_word),
	.flush_queue (flush_queue),
	.stall_stop  (stall_stop)
);
